FILE: rtl/pflvr_pkg.sv
// shared types and constants for the push-front list with value removal
package pflvr_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int VALUE_W    = 32;
  localparam int COUNT_W    = $clog2(LIST_DEPTH + 1);
  localparam int ENTRY_W    = 5;

  typedef enum logic {
    OP_PUSH   = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // contents of one list slot
  typedef struct packed {
    logic                      occ;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic remove;
  } cell_ctl_t;

endpackage

FILE: rtl/pflvr_cell.sv
// one list slot: holds a value, compares it with the key and shifts with its neighbors
module pflvr_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  pflvr_pkg::cell_ctl_t                ctl,
  input  logic signed [pflvr_pkg::VALUE_W-1:0] key,
  input  pflvr_pkg::slot_t                    prev_slot,
  input  pflvr_pkg::slot_t                    next_slot,
  input  logic                                match_in,
  output logic                                match_out,
  output pflvr_pkg::slot_t                    slot,
  output pflvr_pkg::slot_t                    slot_next
);

  logic hit_here;

  assign hit_here  = slot.occ && (slot.value == key);
  assign match_out = match_in | hit_here;

  // push moves everything back; a removal closes up from the first match onward
  always_comb begin
    slot_next = slot;
    if (ctl.push) begin
      slot_next = prev_slot;
    end else if (ctl.remove && match_out) begin
      slot_next = next_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.occ <= 1'b0;
    end else begin
      slot.occ <= slot_next.occ;
    end
    slot.value <= slot_next.value;
  end

endmodule

FILE: rtl/push_front_list_with_value_removal_unit.sv
// Bounded push-front list of signed 32-bit values with removal of the first matching entry.
// The list is a row of LIST_DEPTH cells; every cell compares its value with the request
// value in parallel and a priority chain through the row marks the first match, so each
// request is resolved combinationally and its result is registered, appearing on the response
// port the cycle after the request is taken. A new request is taken every cycle as long
// as the response register is empty or being emptied; a response held under stall holds
// the request side in stall. Status: 0 ok, 1 not found, 2 full (push dropped), 3 empty.
module push_front_list_with_value_removal_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [0:0]                           opcode,
  input  logic signed [pflvr_pkg::VALUE_W-1:0] value,
  output logic                                 rsp_valid,
  input  logic                                 rsp_stall,
  output logic [pflvr_pkg::ENTRY_W-1:0]        entry_count,
  output logic signed [pflvr_pkg::VALUE_W-1:0] front_value,
  output logic [1:0]                           status
);

  pflvr_pkg::slot_t                     slots      [pflvr_pkg::LIST_DEPTH];
  pflvr_pkg::slot_t                     slots_next [pflvr_pkg::LIST_DEPTH];
  logic [pflvr_pkg::LIST_DEPTH:0]       match;
  logic [pflvr_pkg::LIST_DEPTH-1:0]     occ_vec;
  pflvr_pkg::cell_ctl_t                 ctl;
  logic                                 accept;
  logic                                 is_push;
  logic                                 full;
  logic                                 empty;
  logic                                 hit_any;
  logic [pflvr_pkg::COUNT_W-1:0]        count;
  logic [pflvr_pkg::COUNT_W-1:0]        count_next;
  pflvr_pkg::status_t                   status_next;

  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  assign is_push   = (opcode == pflvr_pkg::OP_PUSH);

  assign full    = slots[pflvr_pkg::LIST_DEPTH-1].occ;
  assign empty   = ~slots[0].occ;
  assign match[0] = 1'b0;
  assign hit_any = match[pflvr_pkg::LIST_DEPTH];

  assign ctl.push   = accept & is_push & ~full;
  assign ctl.remove = accept & ~is_push & hit_any;

  for (genvar i = 0; i < pflvr_pkg::LIST_DEPTH; i++) begin : g_cell
    pflvr_pkg::slot_t prev_slot;
    pflvr_pkg::slot_t next_slot;

    if (i == 0) begin : g_head
      assign prev_slot = '{occ: 1'b1, value: value};
    end else begin : g_mid
      assign prev_slot = slots[i-1];
    end

    if (i == pflvr_pkg::LIST_DEPTH - 1) begin : g_tail
      assign next_slot = '{occ: 1'b0, value: '0};
    end else begin : g_body
      assign next_slot = slots[i+1];
    end

    assign occ_vec[i] = slots[i].occ;

    pflvr_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .key       (value),
      .prev_slot (prev_slot),
      .next_slot (next_slot),
      .match_in  (match[i]),
      .match_out (match[i+1]),
      .slot      (slots[i]),
      .slot_next (slots_next[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.remove) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    status_next = pflvr_pkg::ST_OK;
    if (is_push) begin
      if (full) begin
        status_next = pflvr_pkg::ST_FULL;
      end
    end else if (empty) begin
      status_next = pflvr_pkg::ST_EMPTY;
    end else if (!hit_any) begin
      status_next = pflvr_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_count <= pflvr_pkg::ENTRY_W'(count_next);
      front_value <= slots_next[0].occ ? slots_next[0].value : '0;
      status      <= status_next;
    end
  end

`ifndef SYNTHESIS
  // occupied cells always form one run from the front
  a_thermometer: assert property (@(posedge clk) disable iff (rst)
    (occ_vec & (occ_vec + 1'b1)) == '0)
    else $error("occupied cells are not contiguous from the front");

  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    $countones(occ_vec) == int'(count))
    else $error("entry count disagrees with occupied cells");

  a_push_front: assert property (@(posedge clk) disable iff (rst)
    ctl.push |=> rsp_valid && (front_value == $past(value)) && slots[0].occ)
    else $error("pushed value is not at the front");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == pflvr_pkg::ST_EMPTY) |-> (entry_count == '0) && (front_value == '0))
    else $error("empty status with a nonempty list");

  a_no_change: assert property (@(posedge clk) disable iff (rst)
    accept && !ctl.push && !ctl.remove |=> $stable(occ_vec) && $stable(count))
    else $error("list changed on a dropped or missed request");
`endif

endmodule
